// ----- src/arh_pkg.sv -----
// Package with shared types and constants of the auto-range histogram unit.
`timescale 1ns / 1ps

package arh_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned MAX_BINS_DEF    = 64;
  localparam int unsigned SAMPLE_W_DEF    = 32;

  localparam int unsigned BIN_IDX_W = 6;
  localparam int unsigned BIN_CNT_W = 7;
  localparam int unsigned TOTAL_W   = 13;

  localparam logic [BIN_CNT_W-1:0] BINS_RESET  = 7'd64;
  localparam logic [TOTAL_W-1:0]   COUNT_LIMIT = 13'h1FFF;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_SPAN = 15'h0002,
    S_SRD  = 15'h0004,
    S_SMUL = 15'h0008,
    S_SGO  = 15'h0010,
    S_SDIV = 15'h0020,
    S_CRD  = 15'h0040,
    S_CWR  = 15'h0080,
    S_BMUL = 15'h0100,
    S_BGO  = 15'h0200,
    S_BDIV = 15'h0400,
    S_BRD  = 15'h0800,
    S_BLD  = 15'h1000,
    S_OUT  = 15'h2000,
    S_CLR  = 15'h4000
  } arh_state_t;

  typedef struct packed {
    logic load;
    logic span_load;
    logic j_next;
    logic mul_smp;
    logic mul_ctr;
    logic div_go_smp;
    logic div_go_ctr;
    logic idx_load;
    logic cnt_rd_bin;
    logic cnt_wr;
    logic ctr_load;
    logic out_load;
    logic i_next;
    logic clear;
  } arh_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last_smp;
    logic last_bin;
    logic out_taken;
  } arh_sts_t;

endpackage

// ----- src/arh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module arh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- src/arh_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module arh_divider #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   dvd_r, dvd_nxt;
  logic [DW-1:0]   dsr_r;
  logic [DW:0]     rem_r, rem_nxt, rem_sh;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;

  always_comb begin
    rem_sh  = {rem_r[DW-1:0], dvd_r[NW-1]};
    dvd_nxt = {dvd_r[NW-2:0], 1'b0};
    rem_nxt = rem_sh;
    if (rem_sh >= {1'b0, dsr_r}) begin
      rem_nxt    = rem_sh - {1'b0, dsr_r};
      dvd_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

// ----- src/arh_ctrl.sv -----
// Controller state machine that sequences loading, binning and result output.
`timescale 1ns / 1ps

module arh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_sample,
  output logic              in_stall,
  input  arh_pkg::arh_sts_t sts,
  output arh_pkg::arh_cmd_t cmd
);
  import arh_pkg::*;

  arh_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_sample) begin
            state_nxt = S_SPAN;
          end
        end
      end
      S_SPAN: begin
        cmd.span_load = 1'b1;
        state_nxt     = S_SRD;
      end
      S_SRD:  state_nxt = S_SMUL;
      S_SMUL: begin
        cmd.mul_smp = 1'b1;
        state_nxt   = S_SGO;
      end
      S_SGO: begin
        cmd.div_go_smp = 1'b1;
        state_nxt      = S_SDIV;
      end
      S_SDIV: begin
        if (!sts.div_busy) begin
          cmd.idx_load = 1'b1;
          state_nxt    = S_CRD;
        end
      end
      S_CRD:  state_nxt = S_CWR;
      S_CWR: begin
        cmd.cnt_wr = 1'b1;
        if (sts.last_smp) begin
          state_nxt = S_BMUL;
        end else begin
          cmd.j_next = 1'b1;
          state_nxt  = S_SRD;
        end
      end
      S_BMUL: begin
        cmd.mul_ctr = 1'b1;
        state_nxt   = S_BGO;
      end
      S_BGO: begin
        cmd.div_go_ctr = 1'b1;
        state_nxt      = S_BDIV;
      end
      S_BDIV: begin
        if (!sts.div_busy) begin
          cmd.ctr_load = 1'b1;
          state_nxt    = S_BRD;
        end
      end
      S_BRD: begin
        cmd.cnt_rd_bin = 1'b1;
        state_nxt      = S_BLD;
      end
      S_BLD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (sts.out_taken) begin
          if (sts.last_bin) begin
            state_nxt = S_CLR;
          end else begin
            cmd.i_next = 1'b1;
            state_nxt  = S_BMUL;
          end
        end
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- src/arh_datapath.sv -----
// Datapath: sample store, range tracking, multiplier, divider and bin counters.
`timescale 1ns / 1ps

module arh_datapath #(
  parameter int unsigned MAX_SAMPLES  = arh_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned MAX_BINS     = arh_pkg::MAX_BINS_DEF,
  parameter int unsigned SAMPLE_WIDTH = arh_pkg::SAMPLE_W_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  arh_pkg::arh_cmd_t                    cmd,
  output arh_pkg::arh_sts_t                    sts,
  input  logic                                 cfg_we,
  input  logic [arh_pkg::BIN_CNT_W-1:0]        cfg_bin_count,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [arh_pkg::BIN_IDX_W-1:0]        out_bin_index,
  output logic signed [SAMPLE_WIDTH-1:0]       out_bin_center,
  output logic [arh_pkg::TOTAL_W-1:0]          out_bin_total,
  output logic signed [SAMPLE_WIDTH-1:0]       out_lowest_value,
  output logic signed [SAMPLE_WIDTH-1:0]       out_highest_value,
  output logic                                 out_last_bin
);
  import arh_pkg::*;

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned NW  = SW + 8;
  localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BIW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  localparam logic signed [SW-1:0] MOST_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

  logic [BIN_CNT_W-1:0]  bins_r, bins_eff;
  logic [CW-1:0]         count_r;
  logic signed [SW-1:0]  min_r, max_r, center_r;
  logic [SW-1:0]         span_r, diff;
  logic [AW-1:0]         j_r;
  logic [BIW-1:0]        i_r, idx_r, idx_nxt;
  logic [NW-1:0]         mul_r, quot;
  logic                  div_busy;
  logic                  store_we;
  logic [SW-1:0]         store_q;
  logic [BIW-1:0]        cnt_raddr;
  logic [TOTAL_W-1:0]    cnt_q, cnt_val, cnt_inc;
  logic [MAX_BINS-1:0]   cnt_vld_r;
  logic                  cvld_q_r;
  logic                  out_valid_r;
  logic [BIN_CNT_W-1:0]  bins_m1;

  // Bin count as used: zero taken as one, large values limited.
  always_comb begin
    bins_eff = bins_r;
    if (bins_r == '0) begin
      bins_eff = BIN_CNT_W'(1);
    end else if (bins_r > BIN_CNT_W'(MAX_BINS)) begin
      bins_eff = BIN_CNT_W'(MAX_BINS);
    end
  end
  assign bins_m1 = bins_eff - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= BINS_RESET;
    end else if (cfg_we) begin
      bins_r <= cfg_bin_count;
    end
  end

  assign store_we = cmd.load && (count_r < CW'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      min_r   <= MOST_POS;
      max_r   <= MOST_NEG;
    end else if (store_we) begin
      count_r <= count_r + 1'b1;
      if (in_sample < min_r) begin
        min_r <= in_sample;
      end
      if (in_sample > max_r) begin
        max_r <= in_sample;
      end
    end
  end

  arh_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_store (
    .clk    (clk),
    .we     (store_we),
    .waddr  (count_r[AW-1:0]),
    .wdata  (in_sample),
    .raddr  (j_r),
    .rdata_r(store_q)
  );

  assign diff = store_q - min_r;

  always_ff @(posedge clk) begin
    if (cmd.span_load) begin
      span_r <= max_r - min_r;
    end
    if (cmd.mul_smp) begin
      mul_r <= NW'(diff) * NW'(bins_eff);
    end else if (cmd.mul_ctr) begin
      mul_r <= NW'(span_r) * NW'({i_r, 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.span_load) begin
      j_r <= '0;
      i_r <= '0;
    end else begin
      if (cmd.j_next) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.i_next) begin
        i_r <= i_r + 1'b1;
      end
    end
  end

  arh_divider #(.NW(NW), .DW(SW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_go_smp || cmd.div_go_ctr),
    .dividend(mul_r),
    .divisor (cmd.div_go_smp ? span_r : SW'({bins_eff, 1'b0})),
    .busy    (div_busy),
    .quotient(quot)
  );

  // A zero span puts everything in the first bin; the top edge is clamped.
  always_comb begin
    if (span_r == '0) begin
      idx_nxt = '0;
    end else if (quot > NW'(bins_m1)) begin
      idx_nxt = bins_m1[BIW-1:0];
    end else begin
      idx_nxt = quot[BIW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_load) begin
      idx_r <= idx_nxt;
    end
    if (cmd.ctr_load) begin
      center_r <= min_r + ((span_r == '0) ? '0 : quot[SW-1:0]);
    end
  end

  assign cnt_raddr = cmd.cnt_rd_bin ? i_r : idx_r;

  arh_ram #(.WIDTH(TOTAL_W), .DEPTH(MAX_BINS)) u_bins (
    .clk    (clk),
    .we     (cmd.cnt_wr),
    .waddr  (idx_r),
    .wdata  (cnt_inc),
    .raddr  (cnt_raddr),
    .rdata_r(cnt_q)
  );

  assign cnt_val = cvld_q_r ? cnt_q : '0;
  assign cnt_inc = (cnt_val == COUNT_LIMIT) ? cnt_val : cnt_val + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_vld_r <= '0;
    end else if (cmd.cnt_wr) begin
      cnt_vld_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cvld_q_r <= cnt_vld_r[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bin_index     <= BIN_IDX_W'(i_r);
      out_bin_center    <= center_r;
      out_bin_total     <= cnt_val;
      out_lowest_value  <= min_r;
      out_highest_value <= max_r;
      out_last_bin      <= sts.last_bin;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.div_busy  = div_busy;
  assign sts.last_smp  = (CW'(j_r) == count_r - 1'b1);
  assign sts.last_bin  = (BIN_CNT_W'(i_r) == bins_m1);
  assign sts.out_taken = out_valid_r && !out_stall;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_wr |-> (BIN_CNT_W'(idx_r) < bins_eff))
    else $error("bin counter written beyond the active bins");

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (BIN_CNT_W'(i_r) < bins_eff))
    else $error("result item for a bin beyond the active bins");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("result item loaded over one not yet taken");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_go_smp || cmd.div_go_ctr) |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule

// ----- src/auto_range_histogram_unit.sv -----
// Top level of the auto-range equal-width histogram unit.
`timescale 1ns / 1ps

// Usage:
// Items enter on in_valid/in_stall, each a signed sample plus a last_sample
// flag. One item is accepted per cycle while loading; it is stored and the
// running minimum and maximum are updated. Samples beyond MAX_SAMPLES are
// dropped, although a final one still closes the set.
// The item with last_sample set closes the set and starts binning; in_stall
// stays high until the last result item has been taken.
// Binning takes the stored samples one at a time, each through the bit-serial
// divider that forms its bin index. Then one result item per bin leaves on
// out_valid/out_stall, in ascending order, with last_bin on the final one;
// the centre of each bin is also formed by the divider. A stalled result item
// is held in the output register until taken.
// After the final result the counters and range reset and loading resumes.
// The bin count is written through cfg_valid/cfg_ready; the user must write it
// only while idle, as the block does not enforce this. Zero acts as one bin and
// values above MAX_BINS act as MAX_BINS. Synchronous active-low reset clears
// the set and sets the bin count to 64; no clearing pass is needed.
module auto_range_histogram_unit #(
  parameter int unsigned MAX_SAMPLES  = arh_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned MAX_BINS     = arh_pkg::MAX_BINS_DEF,
  parameter int unsigned SAMPLE_WIDTH = arh_pkg::SAMPLE_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_last_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [arh_pkg::BIN_IDX_W-1:0]  out_bin_index,
  output logic signed [SAMPLE_WIDTH-1:0] out_bin_center,
  output logic [arh_pkg::TOTAL_W-1:0]    out_bin_total,
  output logic signed [SAMPLE_WIDTH-1:0] out_lowest_value,
  output logic signed [SAMPLE_WIDTH-1:0] out_highest_value,
  output logic                           out_last_bin,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arh_pkg::BIN_CNT_W-1:0]  cfg_bin_count
);
  import arh_pkg::*;

  arh_cmd_t cmd;
  arh_sts_t sts;

  // The bin count register can always take a write.
  assign cfg_ready = 1'b1;

  arh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_sample(in_last_sample),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  arh_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_bin_count    (cfg_bin_count),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bin_index    (out_bin_index),
    .out_bin_center   (out_bin_center),
    .out_bin_total    (out_bin_total),
    .out_lowest_value (out_lowest_value),
    .out_highest_value(out_highest_value),
    .out_last_bin     (out_last_bin)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the auto-range equal-width histogram unit.
`timescale 1ns / 1ps

module tb_top;
  import arh_pkg::*;

  localparam int unsigned NBINS_MAX = 64;
  localparam int unsigned STORE_DEPTH = 4096;

  typedef struct packed {
    logic signed [31:0] sample;
    logic last_sample;
  } sample_item_t;

  typedef struct packed {
    logic [5:0] bin_index;
    logic signed [31:0] bin_center;
    logic [12:0] bin_total;
    logic signed [31:0] lowest_value;
    logic signed [31:0] highest_value;
    logic last_bin;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_sample = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_bin_index;
  logic signed [31:0] out_bin_center;
  logic [12:0] out_bin_total;
  logic signed [31:0] out_lowest_value;
  logic signed [31:0] out_highest_value;
  logic out_last_bin;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_bin_count = '0;

  auto_range_histogram_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bin_index(out_bin_index), .out_bin_center(out_bin_center),
    .out_bin_total(out_bin_total), .out_lowest_value(out_lowest_value),
    .out_highest_value(out_highest_value), .out_last_bin(out_last_bin),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_bin_count(cfg_bin_count)
  );

  always #5 clk = ~clk;

  // Shadow state of the histogram: the samples of the current set, its range
  // and the bin count in force.
  logic signed [31:0] set_samples[$];
  logic signed [31:0] set_min = 32'sh7FFFFFFF;
  logic signed [31:0] set_max = 32'sh80000000;
  logic [6:0] bins_reg = BINS_RESET;

  sample_item_t pending_samples[$];
  bin_result_t expected_bins[$];
  int errors = 0;

  // Idle rates in percent; the initial block moves these through the phases.
  int send_idle_pct = 35;
  int recv_idle_pct = 72;
  int hold_off_cycles = 0;

  // Models one accepted sample. A final sample closes the set: every stored
  // sample is counted into its bin and one expected result per bin is queued.
  task automatic absorb_sample(input sample_item_t it);
    int unsigned nb;
    logic [63:0] span, umin, d, idx, off;
    int unsigned counts[NBINS_MAX];
    bin_result_t r;
    if (set_samples.size() < STORE_DEPTH) begin
      set_samples.push_back(it.sample);
      if (it.sample < set_min) set_min = it.sample;
      if (it.sample > set_max) set_max = it.sample;
    end
    if (!it.last_sample) return;
    nb = bins_reg;
    if (nb < 1) nb = 1;
    if (nb > NBINS_MAX) nb = NBINS_MAX;
    // The span is taken on 64-bit sign-extended values, so it never wraps.
    umin = {{32{set_min[31]}}, set_min};
    span = {{32{set_max[31]}}, set_max} - umin;
    foreach (counts[k]) counts[k] = 0;
    foreach (set_samples[k]) begin
      idx = 0;
      if (span != 0) begin
        d = {{32{set_samples[k][31]}}, set_samples[k]} - umin;
        idx = (d * nb) / span;
      end
      if (idx > nb - 1) idx = nb - 1;
      if (counts[idx] < COUNT_LIMIT) counts[idx]++;
    end
    for (int unsigned i = 0; i < nb; i++) begin
      off = ((2 * i + 1) * span) / (2 * nb);
      r.bin_index = i[5:0];
      r.bin_center = 32'(umin + off);
      r.bin_total = counts[i][12:0];
      r.lowest_value = set_min;
      r.highest_value = set_max;
      r.last_bin = (i == nb - 1);
      expected_bins.push_back(r);
    end
    set_samples.delete();
    set_min = 32'sh7FFFFFFF;
    set_max = 32'sh80000000;
  endtask

  // Driver: offers the next pending item, holding it while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        absorb_sample('{in_sample, in_last_sample});
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_item_t nx;
          nx = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_sample <= nx.sample;
          in_last_sample <= nx.last_sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result against the oldest expectation and
  // decides the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        bin_result_t got, want;
        got = '{out_bin_index, out_bin_center, out_bin_total, out_lowest_value,
                out_highest_value, out_last_bin};
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_bins.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic queue_sample(input logic signed [31:0] v, input logic last);
    pending_samples.push_back('{v, last});
  endtask

  // Random set: all samples equal, or from a narrow band so that ties show up,
  // or spread over the whole range, the mode being drawn once per set.
  task automatic queue_random_set(input int n);
    logic signed [31:0] base;
    int mode;
    base = $urandom;
    mode = $urandom_range(3);
    for (int k = 0; k < n; k++) begin
      logic signed [31:0] v;
      case (mode)
        0: v = base;
        1: v = base + $urandom_range(15);
        default: v = $urandom;
      endcase
      queue_sample(v, k == n - 1);
    end
  endtask

  // Waits until every item is sent and every result has come, then lets the
  // block settle before a register write.
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_bins.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_bins(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_bin_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bins_reg = value;
  endtask

  initial begin
    logic [6:0] bin_settings[6];
    bin_settings = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd3};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets at the reset bin count: field extremes that span the full signed
    // range, a single sample, all-equal samples, and a set of two samples.
    queue_sample(32'sh80000000, 1'b0);
    queue_sample(32'sh7FFFFFFF, 1'b0);
    queue_sample(32'sh00000000, 1'b0);
    queue_sample(32'shFFFFFFFF, 1'b1);
    queue_sample(32'sh00010000, 1'b1);
    for (int k = 0; k < 4; k++) queue_sample(-32'sd5, k == 3);
    queue_sample(32'sh55555555, 1'b0);
    queue_sample(32'shAAAAAAAA, 1'b1);
    drain();

    // Random sets over several bin counts; the idle pattern moves through
    // its three phases, two bin counts each.
    foreach (bin_settings[s]) begin
      write_bins(bin_settings[s]);
      case (s / 2)
        0: begin send_idle_pct = 35; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 8; n++) queue_random_set($urandom_range(1, 8));
      // Long receiver hold-off while the sender keeps offering items.
      if (s == 2) begin
        hold_off_cycles = 3000;
        queue_random_set(4);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
src/arh_pkg.sv
src/arh_ram.sv
src/arh_divider.sv
src/arh_ctrl.sv
src/arh_datapath.sv
src/auto_range_histogram_unit.sv
dv/tb_top.sv
